@@ design/hfmg_pkg.sv @@
// hfmg_pkg: shared types, register codes and fixed-point constants for the
// homomorphic filter mask generator. No dependencies.
`default_nettype none

package hfmg_pkg;

    localparam int GH_W       = 7;
    localparam int SHARP_W    = 7;
    localparam int CUT_W      = 10;
    localparam int PLANE_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int GAIN_W     = 16;

    localparam int Q30        = 30;
    localparam int E_W        = Q30 + 1;
    localparam logic [E_W-1:0] ONE_Q30 = E_W'(64'd1 << Q30);
    localparam int EXP_TERMS  = 16;
    localparam int MAX_WHOLE  = 32;
    localparam int WHOLE_W    = 5;
    localparam int DEN_W      = 2 * CUT_W;
    localparam int QUOT_W     = WHOLE_W + Q30;
    localparam int C25_W      = 12;
    localparam int SHARP_MUL  = 25;
    localparam int ROUND_HALF = 5;
    localparam int DIV_TEN    = 10;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_GAIN  = 3'd0,
        REG_LOW_GAIN   = 3'd1,
        REG_SHARPNESS  = 3'd2,
        REG_CUTOFF     = 3'd3,
        REG_PLANE_ROWS = 3'd4,
        REG_PLANE_COLS = 3'd5
    } t_reg_idx;

    // how the exponential factor is settled for an item
    typedef enum logic [1:0] {
        MODE_CALC,
        MODE_ZERO,
        MODE_ONE
    } t_mode;

    typedef struct packed {
        logic [Q30-1:0]     f;
        logic [WHOLE_W-1:0] k;
        t_mode              mode;
        logic [E_W-1:0]     sum;
    } t_xctx;

    // elaboration only: truncated Taylor series for exp(-f), f in Q30
    function automatic logic [E_W-1:0] exp_neg_q30(input logic [E_W-1:0] f);
        logic [63:0]        term;
        logic signed [33:0] sum;
        term = 64'(ONE_Q30);
        sum  = 34'(ONE_Q30);
        for (int n = 1; n <= EXP_TERMS; n++) begin
            term = ((term * 64'(f)) >> Q30) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - $signed({3'b000, term[E_W-1:0]});
            end else begin
                sum = sum + $signed({3'b000, term[E_W-1:0]});
            end
            if (sum < 0) begin
                sum = '0;
            end
        end
        return sum[E_W-1:0];
    endfunction

    localparam logic [E_W-1:0] EXP_NEG_ONE = exp_neg_q30(ONE_Q30);

endpackage

`default_nettype wire

@@ design/hfmg_ifs.sv @@
// Valid/ready channel interfaces of the mask generator: coordinate input,
// gain output and register write port. Depends on hfmg_pkg.
`default_nettype none

interface hfmg_coord_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] row_index;
    logic [COORD_BITS-1:0] col_index;
    modport source (output valid, row_index, col_index, input ready);
    modport sink   (input valid, row_index, col_index, output ready);
endinterface

interface hfmg_gain_if ();
    import hfmg_pkg::*;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;
    modport source (output valid, gain, input ready);
    modport sink   (input valid, gain, output ready);
endinterface

interface hfmg_cfg_if ();
    import hfmg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

@@ design/homomorphic_filter_mask_gen.sv @@
// Homomorphic filter mask generator: gain H = gl + (gh-gl)*(1-exp(-c*D2/d0^2))
// per frequency bin, fully pipelined. Depends on hfmg_pkg and hfmg_ifs.
//
// Usage:
//   i_coord  : one beat per bin (row_index, col_index).
//   o_gain   : one beat per bin, unsigned gain with GAIN_FRAC_BITS fraction bits,
//              in the order the coordinates came in.
//   i_cfg    : register writes (index, data), always ready; write only while
//              no bin is in flight.
// Throughput: one bin per cycle while the output buffer is not full. Each bin
// passes through the 35-step divider, the 16 Taylor terms at three
// stages each and the 31 stages of repeated exp(-1) scaling.
// All stages move together on one advance signal; a two-beat output buffer
// sits at the end, so input keeps flowing while one result waits. When the
// buffer is full the pipeline freezes and i_coord.ready drops; nothing is
// lost or repeated.
// Reset (synchronous, active low) clears all valid bits and the output
// buffer and loads the register defaults (gh 2.0, gl 0.5, c 5, d0 8.0,
// 512 x 512 plane).
`default_nettype none

module homomorphic_filter_mask_gen #(
    parameter int COORD_BITS     = 12,
    parameter int GAIN_FRAC_BITS = 12
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    hfmg_coord_if.sink  i_coord,
    hfmg_gain_if.source o_gain,
    hfmg_cfg_if.sink    i_cfg
);
    import hfmg_pkg::*;

    localparam int DW      = ((COORD_BITS + 1 > PLANE_W) ? COORD_BITS + 1 : PLANE_W) + 1;
    localparam int SQ_W    = 2 * (DW - 1);
    localparam int QW      = SQ_W + 1;
    localparam int NUM_W   = C25_W + QW;
    localparam int PROD_W  = GH_W + E_W;
    localparam int SHIFT   = Q30 - GAIN_FRAC_BITS;
    localparam int VW      = PROD_W - SHIFT + 1;
    localparam int RS      = VW + 4;
    localparam int RW      = VW + RS;
    localparam logic [RS-1:0] M10 = RS'((64'd1 << RS) / DIV_TEN);

    // ---------------- configuration ----------------
    logic [GH_W-1:0]    r_gh, r_gl;
    logic [SHARP_W-1:0] r_sharp;
    logic [CUT_W-1:0]   r_cut;
    logic [PLANE_W-1:0] r_rows, r_cols;
    logic [DEN_W-1:0]   r_den;
    logic [C25_W-1:0]   r_c25;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gh    <= GH_W'(20);
            r_gl    <= GH_W'(5);
            r_sharp <= SHARP_W'(5);
            r_cut   <= CUT_W'(80);
            r_rows  <= PLANE_W'(512);
            r_cols  <= PLANE_W'(512);
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_HIGH_GAIN:  r_gh    <= i_cfg.wdata[GH_W-1:0];
                REG_LOW_GAIN:   r_gl    <= i_cfg.wdata[GH_W-1:0];
                REG_SHARPNESS:  r_sharp <= i_cfg.wdata[SHARP_W-1:0];
                REG_CUTOFF:     r_cut   <= i_cfg.wdata[CUT_W-1:0];
                REG_PLANE_ROWS: r_rows  <= i_cfg.wdata[PLANE_W-1:0];
                REG_PLANE_COLS: r_cols  <= i_cfg.wdata[PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    // derived constants, stable long before an item needs them
    always_ff @(posedge i_clk) begin
        r_den <= DEN_W'(r_cut) * DEN_W'(r_cut);
        r_c25 <= C25_W'(r_sharp) * C25_W'(SHARP_MUL);
    end

    // ---------------- advance / output buffer ----------------
    logic        w_adv;
    logic [1:0]  r_ob_cnt;
    logic [GAIN_W-1:0] r_ob_data [0:1];
    logic [GAIN_W-1:0] n_ob_data [0:1];
    logic        w_push, w_pop;
    logic [GAIN_W-1:0] w_gain;
    logic        r_f3_v;

    assign w_adv         = (r_ob_cnt != 2'd2);
    assign i_coord.ready = w_adv;

    // ---------------- P1: offsets from centre (times two) ----------------
    logic                 r_p1_v;
    logic signed [DW-1:0] r_p1_dr, r_p1_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_adv) begin
            r_p1_v <= i_coord.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_dr <= DW'({i_coord.row_index, 1'b0}) - DW'(r_rows);
            r_p1_dc <= DW'({i_coord.col_index, 1'b0}) - DW'(r_cols);
        end
    end

    // ---------------- P2: squares ----------------
    logic                   r_p2_v;
    logic [SQ_W-1:0]        r_p2_sqr, r_p2_sqc;
    logic signed [2*DW-1:0] w_sqr, w_sqc;

    assign w_sqr = r_p1_dr * r_p1_dr;
    assign w_sqc = r_p1_dc * r_p1_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_adv) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2_sqr <= w_sqr[SQ_W-1:0];
            r_p2_sqc <= w_sqc[SQ_W-1:0];
        end
    end

    // ---------------- P3: Q = 4 * D2 ----------------
    logic          r_p3_v;
    logic [QW-1:0] r_p3_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_adv) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p3_q <= QW'(r_p2_sqr) + QW'(r_p2_sqc);
        end
    end

    // ---------------- P4: exponent numerator 25*c*Q ----------------
    logic             r_p4_v;
    logic [NUM_W-1:0] r_p4_num;
    t_mode            r_p4_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_adv) begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p4_num <= NUM_W'(r_c25) * NUM_W'(r_p3_q);
            if (r_cut == '0) begin
                r_p4_mode <= (r_p3_q == '0) ? MODE_ONE : MODE_ZERO;
            end else begin
                r_p4_mode <= MODE_CALC;
            end
        end
    end

    // ---------------- divider: num * 2^30 / den, one bit per stage ----------------
    // Whole part of 32 or more flushes exp to zero; otherwise num/32 < den
    // seeds the remainder and 35 quotient bits follow.
    logic               r_dv_v    [0:QUOT_W];
    logic [DEN_W-1:0]   r_dv_rem  [0:QUOT_W];
    logic [QUOT_W-1:0]  r_dv_quo  [0:QUOT_W];
    logic [WHOLE_W-1:0] r_dv_lo   [0:QUOT_W];
    t_mode              r_dv_mode [0:QUOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rem[0] <= r_p4_num[WHOLE_W +: DEN_W];
            r_dv_lo[0]  <= r_p4_num[WHOLE_W-1:0];
            r_dv_quo[0] <= '0;
            if (r_p4_mode == MODE_CALC && r_p4_num >= NUM_W'({r_den, {WHOLE_W{1'b0}}})) begin
                r_dv_mode[0] <= MODE_ZERO;
            end else begin
                r_dv_mode[0] <= r_p4_mode;
            end
        end
    end

    for (genvar s = 1; s <= QUOT_W; s++) begin : g_div
        logic [DEN_W:0] w_trial;
        logic           w_ge;

        assign w_trial = {r_dv_rem[s-1], r_dv_lo[s-1][WHOLE_W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[s] <= r_dv_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[s]  <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                r_dv_quo[s]  <= {r_dv_quo[s-1][QUOT_W-2:0], w_ge};
                r_dv_lo[s]   <= {r_dv_lo[s-1][WHOLE_W-2:0], 1'b0};
                r_dv_mode[s] <= r_dv_mode[s-1];
            end
        end
    end

    // ---------------- Taylor series exp(-f), three stages per term ----------------
    logic           r_xc_v    [0:EXP_TERMS];
    logic [E_W-1:0] r_xc_term [0:EXP_TERMS];
    t_xctx          r_xc_ctx  [0:EXP_TERMS];
    logic           r_xa_v    [1:EXP_TERMS];
    logic [2*E_W-2:0] r_xa_p  [1:EXP_TERMS];
    t_xctx          r_xa_ctx  [1:EXP_TERMS];
    logic           r_xb_v    [1:EXP_TERMS];
    logic [E_W-1:0] r_xb_t    [1:EXP_TERMS];
    logic [E_W-1:0] r_xb_qe   [1:EXP_TERMS];
    t_xctx          r_xb_ctx  [1:EXP_TERMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xc_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_xc_v[0] <= r_dv_v[QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xc_term[0] <= ONE_Q30;
            r_xc_ctx[0]  <= '{f:    r_dv_quo[QUOT_W][Q30-1:0],
                               k:    r_dv_quo[QUOT_W][QUOT_W-1:Q30],
                               mode: r_dv_mode[QUOT_W],
                               sum:  ONE_Q30};
        end
    end

    for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_term
        localparam int NTERM = n;
        localparam logic [WHOLE_W-1:0] NDIV = WHOLE_W'(NTERM);
        logic [E_W+4:0]      w_back;
        logic [E_W-1:0]      w_q;
        logic signed [E_W+1:0] w_sum;

        // A: term * f
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_xa_v[n] <= 1'b0;
                r_xb_v[n] <= 1'b0;
                r_xc_v[n] <= 1'b0;
            end else if (w_adv) begin
                r_xa_v[n] <= r_xc_v[n-1];
                r_xb_v[n] <= r_xa_v[n];
                r_xc_v[n] <= r_xb_v[n];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_xa_p[n]   <= (2*E_W-1)'(r_xc_term[n-1]) * (2*E_W-1)'(r_xc_ctx[n-1].f);
                r_xa_ctx[n] <= r_xc_ctx[n-1];
                r_xb_t[n]   <= r_xa_p[n][2*E_W-2:Q30];
                r_xb_ctx[n] <= r_xa_ctx[n];
            end
        end

        // B: quotient estimate by reciprocal (exact for the first term), low by at most one
        if (NTERM == 1) begin : g_one
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_xb_qe[n] <= r_xa_p[n][2*E_W-2:Q30];
                end
            end
        end else begin : g_recip
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NTERM);
            logic [E_W+31:0] w_prod;

            assign w_prod = (E_W+32)'(r_xa_p[n][2*E_W-2:Q30]) * (E_W+32)'(RECIP);

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_xb_qe[n] <= w_prod[E_W+31:32];
                end
            end
        end

        // C: correct quotient, accumulate with alternating sign, clamp at zero
        assign w_back = (E_W+5)'(r_xb_t[n]) - (E_W+5)'(r_xb_qe[n]) * (E_W+5)'(NDIV);
        assign w_q    = (w_back >= (E_W+5)'(NDIV)) ? r_xb_qe[n] + E_W'(1) : r_xb_qe[n];

        if ((NTERM % 2) == 1) begin : g_sub
            assign w_sum = $signed({2'b00, r_xb_ctx[n].sum}) - $signed({2'b00, w_q});
        end else begin : g_add
            assign w_sum = $signed({2'b00, r_xb_ctx[n].sum}) + $signed({2'b00, w_q});
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_xc_term[n] <= w_q;
                r_xc_ctx[n]  <= '{f:    r_xb_ctx[n].f,
                                  k:    r_xb_ctx[n].k,
                                  mode: r_xb_ctx[n].mode,
                                  sum:  (w_sum[E_W+1] ? E_W'(0) : w_sum[E_W-1:0])};
            end
        end
    end

    // ---------------- k-fold scaling by exp(-1) ----------------
    localparam int PW_N = MAX_WHOLE - 1;
    logic               r_pw_v    [0:PW_N];
    logic [E_W-1:0]     r_pw_e    [0:PW_N];
    logic [WHOLE_W-1:0] r_pw_k    [0:PW_N];
    t_mode              r_pw_mode [0:PW_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_pw_v[0] <= r_xc_v[EXP_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pw_e[0]    <= r_xc_ctx[EXP_TERMS].sum;
            r_pw_k[0]    <= r_xc_ctx[EXP_TERMS].k;
            r_pw_mode[0] <= r_xc_ctx[EXP_TERMS].mode;
        end
    end

    for (genvar j = 1; j <= PW_N; j++) begin : g_pow
        logic [2*E_W-1:0] w_prod;

        assign w_prod = (2*E_W)'(r_pw_e[j-1]) * (2*E_W)'(EXP_NEG_ONE);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_v[j] <= 1'b0;
            end else if (w_adv) begin
                r_pw_v[j] <= r_pw_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pw_e[j]    <= (r_pw_k[j-1] > WHOLE_W'(j-1)) ? w_prod[Q30 +: E_W]
                                                              : r_pw_e[j-1];
                r_pw_k[j]    <= r_pw_k[j-1];
                r_pw_mode[j] <= r_pw_mode[j-1];
            end
        end
    end

    // ---------------- gain blend and rounding ----------------
    logic              r_f1_v, r_f2_v;
    logic [PROD_W-1:0] r_f1_hi, r_f1_lo;
    logic [VW-1:0]     r_f2_val, r_f3_val, r_f3_qe;
    logic [E_W-1:0]    w_ef;
    logic [RW-1:0]     w_rprod;
    logic [VW+3:0]     w_back10;
    logic [VW-1:0]     w_g;

    always_comb begin
        case (r_pw_mode[PW_N])
            MODE_ZERO: w_ef = '0;
            MODE_ONE:  w_ef = ONE_Q30;
            MODE_CALC: w_ef = (r_pw_e[PW_N] > ONE_Q30) ? ONE_Q30 : r_pw_e[PW_N];
            default:   w_ef = '0;
        endcase
    end

    assign w_rprod = RW'(r_f2_val) * RW'(M10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_adv) begin
            r_f1_v <= r_pw_v[PW_N];
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_hi  <= PROD_W'(r_gh) * PROD_W'(ONE_Q30 - w_ef);
            r_f1_lo  <= PROD_W'(r_gl) * PROD_W'(w_ef);
            r_f2_val <= VW'((r_f1_hi + r_f1_lo) >> SHIFT) + VW'(ROUND_HALF);
            r_f3_val <= r_f2_val;
            r_f3_qe  <= w_rprod[RS +: VW];
        end
    end

    // divide by ten: estimate is low by at most one
    assign w_back10 = (VW+4)'(r_f3_val) - (VW+4)'(r_f3_qe) * (VW+4)'(DIV_TEN);
    assign w_g      = (w_back10 >= (VW+4)'(DIV_TEN)) ? r_f3_qe + VW'(1) : r_f3_qe;
    assign w_gain   = (w_g[VW-1:GAIN_W] != '0) ? GAIN_MAX : w_g[GAIN_W-1:0];

    // ---------------- two-beat output buffer ----------------
    assign w_push = w_adv && r_f3_v;
    assign w_pop  = o_gain.valid && o_gain.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= 2'd0;
        end else begin
            r_ob_cnt <= r_ob_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_comb begin
        n_ob_data[0] = r_ob_data[0];
        n_ob_data[1] = r_ob_data[1];
        if (w_pop) begin
            n_ob_data[0] = r_ob_data[1];
        end
        if (w_push) begin
            if ((r_ob_cnt - 2'(w_pop)) == 2'd0) begin
                n_ob_data[0] = w_gain;
            end else begin
                n_ob_data[1] = w_gain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob_data[0] <= n_ob_data[0];
        r_ob_data[1] <= n_ob_data[1];
    end

    assign o_gain.valid = (r_ob_cnt != 2'd0);
    assign o_gain.gain  = r_ob_data[0];

    // ---------------- checks ----------------
    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt != 2'd3)
        else $error("output buffer count overflow");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt == 2'd2 |-> !i_coord.ready)
        else $error("input taken while output buffer full");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_f3_v) && $stable(r_f3_val))
        else $error("pipeline moved during stall");

    a_series_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xc_v[EXP_TERMS] |-> r_xc_ctx[EXP_TERMS].sum <= ONE_Q30)
        else $error("exp series above one");

endmodule

`default_nettype wire
